>>> rtl/core/csb_pkg.sv
// ----------------------------------------------------------------------------
// csb_pkg
// types, op codes, status codes and the bin function shared by the cigar
// span check and bin block
// ----------------------------------------------------------------------------
package csb_pkg;

  localparam int SumW    = 44;
  localparam int LastW   = 45;
  localparam int MinShift = 14;
  localparam int NumLvls  = 5;

  // cigar op codes
  localparam logic [3:0] OP_MATCH = 4'd0;
  localparam logic [3:0] OP_INS   = 4'd1;
  localparam logic [3:0] OP_DEL   = 4'd2;
  localparam logic [3:0] OP_SKIP  = 4'd3;
  localparam logic [3:0] OP_SOFT  = 4'd4;
  localparam logic [3:0] OP_EQUAL = 4'd7;
  localparam logic [3:0] OP_DIFF  = 4'd8;
  localparam logic [3:0] OP_BACK  = 4'd9;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_OP   = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic [31:0]        cigar_word;
    logic signed [31:0] start_pos;
    logic               has_reference;
    logic               unmapped;
    logic [30:0]        read_length;
    logic [15:0]        stored_bin;
    logic [15:0]        op_count;
  } csb_req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [15:0]     bin;
    logic [SumW-1:0] reference_span;
  } csb_rsp_t;

  // first bin number of each level, finest level first
  function automatic logic [15:0] lvl_base(input int lvl);
    lvl_base = 16'(((1 << (3 * (NumLvls - lvl))) - 1) / 7);
  endfunction

  // standard bin of [beg, last], smallest level that holds both ends
  function automatic logic [15:0] bam_bin(input logic [30:0] beg,
                                          input logic [LastW-1:0] last);
    logic [31:0] acc;
    logic [LastW-1:0] beg_x;
    acc   = '0;
    beg_x = LastW'(beg);
    for (int lvl = NumLvls - 1; lvl >= 0; lvl--) begin
      if ((beg_x >> (MinShift + 3 * lvl)) == (last >> (MinShift + 3 * lvl))) begin
        acc = 32'(lvl_base(lvl)) + 32'(beg >> (MinShift + 3 * lvl));
      end
    end
    bam_bin = acc[15:0];
  endfunction

endpackage

>>> rtl/core/cigar_span_check_and_bin.sv
// ----------------------------------------------------------------------------
// cigar_span_check_and_bin
// a record's last word waits in the input register, its result in the result register
// throughput: one word per cycle, set by the input register to result register pass,
// save that a record end waits in the input register while the result register is full
// reset: synchronous rst clears both stage valids and all record state
// ----------------------------------------------------------------------------
module cigar_span_check_and_bin
  import csb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  csb_req_t req_data,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output csb_rsp_t rsp_data
);

  logic     held_valid;
  csb_req_t held_word;
  logic     step;
  logic     emit;
  csb_rsp_t result;
  logic     out_free;

  // the held word moves on unless it ends a record and the result slot is busy
  assign step = held_valid && (!emit || out_free);

  // input register, refills in the same cycle it drains
  csb_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_data   (req_data),
    .take       (step),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  // per-record sums, op check and bin at record end
  csb_record u_rec (
    .clk    (clk),
    .rst    (rst),
    .word   (held_word),
    .step   (step),
    .emit   (emit),
    .result (result)
  );

  // result register, loaded only for words that close a record
  csb_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && emit),
    .load_data (result),
    .free      (out_free),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule

>>> rtl/core/csb_in_stage.sv
// ----------------------------------------------------------------------------
// csb_in_stage
// input register: holds one word until the record stage takes it
// ----------------------------------------------------------------------------
module csb_in_stage
  import csb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  csb_req_t req_data,
  input  logic     take,
  output logic     held_valid,
  output csb_req_t held_word
);

  logic     valid;
  csb_req_t word;

  assign req_ready  = !valid || take;
  assign held_valid = valid;
  assign held_word  = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      word <= req_data;
    end
  end

endmodule

>>> rtl/core/csb_record.sv
// ----------------------------------------------------------------------------
// csb_record
// record state, span sums and end-of-record result with bin
// ----------------------------------------------------------------------------
module csb_record
  import csb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  csb_req_t word,
  input  logic     step,
  output logic     emit,
  output csb_rsp_t result
);

  logic            record_open;
  logic [15:0]     ops_left;
  logic [SumW-1:0] query_sum;
  logic [SumW-1:0] reference_sum;
  logic            bad_op_seen;
  logic [31:0]     held_pos;
  logic [1:0]      held_flags;
  logic [30:0]     held_read_length;
  logic [15:0]     held_bin;

  logic            record_open_next;
  logic [15:0]     ops_left_next;
  logic [SumW-1:0] query_sum_next;
  logic [SumW-1:0] reference_sum_next;
  logic            bad_op_seen_next;

  logic [3:0]      op;
  logic [SumW-1:0] len;
  logic            q_op;
  logic            r_op;
  logic [15:0]     ops_dec;

  // operands of the end-of-record check
  logic [31:0]      f_pos;
  logic             f_has_ref;
  logic             f_unmapped;
  logic [30:0]      f_rl;
  logic [15:0]      f_bin;
  logic [SumW-1:0]  span;
  logic [LastW-1:0] last;

  assign op      = word.cigar_word[3:0];
  assign len     = SumW'(word.cigar_word[31:4]);
  assign q_op    = (op == OP_MATCH) || (op == OP_INS) || (op == OP_SOFT) ||
                   (op == OP_EQUAL) || (op == OP_DIFF);
  assign r_op    = (op == OP_MATCH) || (op == OP_DEL) || (op == OP_SKIP) ||
                   (op == OP_EQUAL) || (op == OP_DIFF);
  assign ops_dec = ops_left - 16'd1;

  always_comb begin
    record_open_next   = record_open;
    ops_left_next      = ops_left;
    query_sum_next     = query_sum;
    reference_sum_next = reference_sum;
    bad_op_seen_next   = bad_op_seen;
    f_pos              = held_pos;
    f_has_ref          = held_flags[0];
    f_unmapped         = held_flags[1];
    f_rl               = held_read_length;
    f_bin              = held_bin;
    emit               = 1'b0;
    if (!word.req_type) begin
      query_sum_next     = '0;
      reference_sum_next = '0;
      bad_op_seen_next   = 1'b0;
      ops_left_next      = word.op_count;
      record_open_next   = 1'b1;
      f_pos              = word.start_pos;
      f_has_ref          = word.has_reference;
      f_unmapped         = word.unmapped;
      f_rl               = word.read_length;
      f_bin              = word.stored_bin;
      emit               = (word.op_count == 16'd0);
    end else if (record_open) begin
      if (op > OP_BACK) begin
        bad_op_seen_next = 1'b1;
      end else begin
        if (q_op) begin
          query_sum_next = query_sum + len;
        end
        if (r_op) begin
          reference_sum_next = reference_sum + len;
        end
      end
      ops_left_next = ops_dec;
      emit          = (ops_dec == 16'd0);
    end
    if (emit) begin
      record_open_next = 1'b0;
      ops_left_next    = '0;
    end
  end

  // end-of-record result
  always_comb begin
    span = (f_unmapped || reference_sum_next == '0) ? SumW'(1) : reference_sum_next;
    last = LastW'(f_pos[30:0]) + LastW'(span) - LastW'(1);
    result = '0;
    if (bad_op_seen_next) begin
      result.status = ST_BAD_OP;
    end else if (!f_unmapped && f_rl != '0 && query_sum_next != SumW'(f_rl)) begin
      result.status = ST_MISMATCH;
    end else begin
      result.status         = ST_OK;
      result.reference_span = span;
      result.bin            = (f_has_ref && !f_pos[31]) ? bam_bin(f_pos[30:0], last) : f_bin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_open      <= 1'b0;
      ops_left         <= '0;
      query_sum        <= '0;
      reference_sum    <= '0;
      bad_op_seen      <= 1'b0;
      held_pos         <= '0;
      held_flags       <= '0;
      held_read_length <= '0;
      held_bin         <= '0;
    end else if (step) begin
      record_open   <= record_open_next;
      ops_left      <= ops_left_next;
      query_sum     <= query_sum_next;
      reference_sum <= reference_sum_next;
      bad_op_seen   <= bad_op_seen_next;
      if (!word.req_type) begin
        held_pos         <= word.start_pos;
        held_flags       <= {word.unmapped, word.has_reference};
        held_read_length <= word.read_length;
        held_bin         <= word.stored_bin;
      end
    end
  end

endmodule

>>> rtl/core/csb_out_stage.sv
// ----------------------------------------------------------------------------
// csb_out_stage
// result register toward the downstream side
// ----------------------------------------------------------------------------
module csb_out_stage
  import csb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  csb_rsp_t load_data,
  output logic     free,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output csb_rsp_t rsp_data
);

  logic     valid;
  csb_rsp_t data;

  assign free      = !valid || rsp_ready;
  assign rsp_valid = valid;
  assign rsp_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

>>> rtl/core/csb_checker.sv
// ----------------------------------------------------------------------------
// csb_rsp_checker
// port-level checks on results of the cigar span check and bin block
// ----------------------------------------------------------------------------
module csb_rsp_checker
  import csb_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input csb_rsp_t rsp_data
);

  // a stalled result stays up
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_data))
    else $error("result changed while stalled");

  // error results carry no bin and no span
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != ST_OK |->
      rsp_data.bin == 16'd0 && rsp_data.reference_span == '0)
    else $error("error result with nonzero fields");

  // a good result always has a span of at least one
  a_ok_span: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == ST_OK |-> rsp_data.reference_span != '0)
    else $error("ok result with zero span");

  // nothing comes out right after reset
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind cigar_span_check_and_bin csb_rsp_checker u_csb_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data)
);
